// ===== design/dsm_pkg.sv =====
// Shared types and constants of the disturbance mask unit.
`default_nettype none

package dsm_pkg;

  localparam int ROW_W      = 16;
  localparam int COL_W      = 12;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int THR_W      = 31;
  localparam int IMG_W_W    = 13;
  localparam int IMG_H_W    = 16;
  localparam int NBR        = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_CONN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAG_THRESH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NODATA      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT  = 3'd5;

  // neighbor slots: 2k is the first (upper/left) and 2k+1 the second of direction k
  // direction 0 vertical, 1 horizontal, 2 main diagonal, 3 anti diagonal
  typedef struct packed {
    logic             report;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             ctr_nd;
    logic [NBR-1:0]   nbr_nd;
  } dsm_win_t;

endpackage

`default_nettype wire

// ===== design/dsm_ram.sv =====
// Generic simple dual port RAM with registered read.
`default_nettype none

module dsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/dsm_window.sv =====
// Raster counters, line stores, 3x3 window and height step stage.
`default_nettype none

module dsm_window
  import dsm_pkg::*;
#(
  parameter int MAX_COLS    = 4096,
  parameter int HEIGHT_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [HEIGHT_BITS-1:0]        in_height,
  input  wire logic [HEIGHT_BITS-1:0]        nodata,
  input  wire logic [IMG_W_W-1:0]            image_width,
  input  wire logic [IMG_H_W-1:0]            image_height,
  output logic                               win_valid,
  input  wire logic                          win_ready,
  output dsm_win_t                           win_info,
  output logic signed [HEIGHT_BITS:0]        win_diff [NBR]
);

  localparam int CW   = $clog2(MAX_COLS);
  localparam int CNTW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
  localparam int XW   = (CW > COL_W) ? CW : COL_W;
  localparam int HB   = HEIGHT_BITS;
  localparam int DW   = HEIGHT_BITS + 1;

  logic [CW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic [CW-1:0]    col_count_next;
  logic [ROW_W-1:0] row_count_next;

  logic [CNTW-1:0]  width_eff;
  logic [CNTW-1:0]  iw_ext;
  logic [CNTW-1:0]  col_inc;
  logic [ROW_W:0]   height_eff;
  logic [ROW_W:0]   row_inc;
  logic [XW-1:0]    col_out_ext;

  logic             in_fire;
  logic             adv1;

  logic             v1;
  logic [HB-1:0]    s1_sample;
  logic [CW-1:0]    s1_col;
  logic             s1_report;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col_out;

  logic [HB-1:0]    up_rd;
  logic [HB-1:0]    mid_rd;

  logic [HB-1:0]    win_mid [3];
  logic [HB-1:0]    win_new [3];

  logic [HB-1:0]    ctr;
  logic [HB-1:0]    nbr [NBR];

  assign adv1     = !win_valid || win_ready;
  assign in_ready = !v1 || adv1;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    iw_ext = CNTW'(image_width);
    if (iw_ext < CNTW'(3)) begin
      width_eff = CNTW'(3);
    end else if (iw_ext > CNTW'(MAX_COLS)) begin
      width_eff = CNTW'(MAX_COLS);
    end else begin
      width_eff = iw_ext;
    end
    height_eff = (image_height < IMG_H_W'(3)) ? (ROW_W+1)'(3) : {1'b0, image_height};

    col_inc = CNTW'(col_count) + CNTW'(1);
    row_inc = {1'b0, row_count} + (ROW_W+1)'(1);
    col_count_next = col_inc[CW-1:0];
    row_count_next = row_count;
    if (col_inc >= width_eff) begin
      col_count_next = '0;
      row_count_next = (row_inc >= height_eff) ? '0 : row_inc[ROW_W-1:0];
    end
    col_out_ext = XW'(col_count) - XW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_fire) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // Consecutive beats always hit different columns, so the write-back of one
  // beat never meets the read of the next at the same entry.
  dsm_ram #(.WIDTH(HB), .DEPTH(MAX_COLS)) u_upper (
    .clk   (clk),
    .we    (v1 && adv1),
    .waddr (s1_col),
    .wdata (mid_rd),
    .re    (in_fire),
    .raddr (col_count),
    .rdata (up_rd)
  );

  dsm_ram #(.WIDTH(HB), .DEPTH(MAX_COLS)) u_middle (
    .clk   (clk),
    .we    (v1 && adv1),
    .waddr (s1_col),
    .wdata (s1_sample),
    .re    (in_fire),
    .raddr (col_count),
    .rdata (mid_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample  <= in_height;
      s1_col     <= col_count;
      s1_report  <= (row_count >= ROW_W'(2)) && (col_count >= CW'(2));
      s1_row     <= row_count - ROW_W'(1);
      s1_col_out <= col_out_ext[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_mid[i] <= '0;
        win_new[i] <= '0;
      end
    end else if (v1 && adv1) begin
      for (int i = 0; i < 3; i++) begin
        win_mid[i] <= win_new[i];
      end
      win_new[0] <= up_rd;
      win_new[1] <= mid_rd;
      win_new[2] <= s1_sample;
    end
  end

  // window as it stands after this beat's shift
  always_comb begin
    ctr    = win_new[1];
    nbr[0] = win_new[0];
    nbr[1] = win_new[2];
    nbr[2] = win_mid[1];
    nbr[3] = mid_rd;
    nbr[4] = win_mid[0];
    nbr[5] = s1_sample;
    nbr[6] = up_rd;
    nbr[7] = win_mid[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (adv1) begin
      win_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && adv1) begin
      win_info.report <= s1_report;
      win_info.row    <= s1_row;
      win_info.col    <= s1_col_out;
      win_info.ctr_nd <= (ctr == nodata);
      for (int k = 0; k < NBR; k++) begin
        win_info.nbr_nd[k] <= (nbr[k] == nodata);
      end
      for (int k = 0; k < NBR / 2; k++) begin
        win_diff[2*k]   <= DW'($signed(nbr[2*k])) - DW'($signed(ctr));
        win_diff[2*k+1] <= DW'($signed(ctr)) - DW'($signed(nbr[2*k+1]));
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/dsm_eval.sv =====
// Threshold tests per direction and the result register.
`default_nettype none

module dsm_eval
  import dsm_pkg::*;
#(
  parameter int HEIGHT_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        win_valid,
  output logic                             win_ready,
  input  wire dsm_win_t                    win_info,
  input  wire logic signed [HEIGHT_BITS:0] win_diff [NBR],
  input  wire logic                        four_conn,
  input  wire logic [THR_W-1:0]            threshold,
  input  wire logic [THR_W-1:0]            diag_threshold,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [OUT_W-1:0]                 m_tdata
);

  localparam int DW = HEIGHT_BITS + 1;
  localparam int EW = ((DW > THR_W) ? DW : THR_W) + 1;

  logic signed [EW-1:0] lim_hv;
  logic signed [EW-1:0] lim_dg;
  logic signed [EW-1:0] lim;
  logic signed [EW-1:0] d_ext;
  logic [NBR-1:0]       exceed;
  logic [3:0]           dir_dist;
  logic                 disturbed;

  assign win_ready = !m_tvalid || m_tready;

  always_comb begin
    lim_hv = $signed(EW'(threshold));
    lim_dg = $signed(EW'(diag_threshold));
    for (int k = 0; k < NBR; k++) begin
      lim       = (k < 4) ? lim_hv : lim_dg;
      d_ext     = EW'(win_diff[k]);
      exceed[k] = (d_ext > lim) || (d_ext < -lim);
    end
    for (int j = 0; j < 4; j++) begin
      if (!win_info.nbr_nd[2*j] && !win_info.nbr_nd[2*j+1]) begin
        dir_dist[j] = exceed[2*j] || exceed[2*j+1];
      end else if (win_info.nbr_nd[2*j]) begin
        dir_dist[j] = exceed[2*j+1];
      end else begin
        dir_dist[j] = exceed[2*j];
      end
    end
    disturbed = !win_info.ctr_nd && dir_dist[0] && dir_dist[1]
                && (four_conn || (dir_dist[2] && dir_dist[3]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (win_ready) begin
      m_tvalid <= win_valid && win_info.report;
    end
  end

  always_ff @(posedge clk) begin
    if (win_ready && win_valid) begin
      m_tdata <= {2'b00, win_info.ctr_nd, disturbed, win_info.col, win_info.row};
    end
  end

endmodule

`default_nettype wire

// ===== design/dsm_disturbance_mask_unit.sv =====
// Top level of the disturbance mask unit: configuration registers and pipeline.
//
// Heights enter on the s_ stream in raster order, one beat per pixel, and the
// unit keeps the two previous rows in two line RAMs of MAX_COLS entries plus a
// 3x3 window. Every beat at row r >= 2, column c >= 2 yields one result beat on
// the m_ stream for interior pixel (r-1, c-1); border beats give none.
// Each result passes the RAM read, window and output registers in turn.
// Throughput: one beat per cycle while m_tready is high; each line RAM takes one
// read for the new beat and one write-back for the previous beat in the same cycle.
// Stages: RAM read, window shift with height steps, threshold test into the
// output register. Stages with a bubble keep filling while m_tready is low,
// so up to three beats are held before s_tready drops.
// Reset clears counters, window, valids and the registers to their defaults
// (four-connectivity, zero thresholds and nodata, width 4096, height 65535).
// Line RAMs are not cleared; their stale entries never reach a result.
// Configuration writes are taken on any cycle with cfg_we high and are meant
// for an idle unit.
`default_nettype none

module dsm_disturbance_mask_unit
  import dsm_pkg::*;
#(
  parameter int MAX_COLS    = 4096,
  parameter int HEIGHT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_W-1:0]       s_tdata,   // [31:0] height
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_W-1:0]           m_tdata,   // [15:0] row, [27:16] col,
                                                // [28] disturbed, [29] center_nodata
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic                         four_conn;
  logic [THR_W-1:0]             threshold;
  logic [THR_W-1:0]             diag_threshold;
  logic [HEIGHT_BITS-1:0]       nodata;
  logic [IMG_W_W-1:0]           image_width;
  logic [IMG_H_W-1:0]           image_height;

  logic                         win_valid;
  logic                         win_ready;
  dsm_win_t                     win_info;
  logic signed [HEIGHT_BITS:0]  win_diff [NBR];

  always_ff @(posedge clk) begin
    if (rst) begin
      four_conn      <= 1'b1;
      threshold      <= '0;
      diag_threshold <= '0;
      nodata         <= '0;
      image_width    <= IMG_W_W'(4096);
      image_height   <= IMG_H_W'(65535);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FOUR_CONN:   four_conn      <= cfg_data[0];
        CFG_THRESHOLD:   threshold      <= cfg_data[THR_W-1:0];
        CFG_DIAG_THRESH: diag_threshold <= cfg_data[THR_W-1:0];
        CFG_NODATA:      nodata         <= cfg_data[HEIGHT_BITS-1:0];
        CFG_IMG_WIDTH:   image_width    <= cfg_data[IMG_W_W-1:0];
        CFG_IMG_HEIGHT:  image_height   <= cfg_data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  dsm_window #(
    .MAX_COLS    (MAX_COLS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_height    (s_tdata[HEIGHT_BITS-1:0]),
    .nodata       (nodata),
    .image_width  (image_width),
    .image_height (image_height),
    .win_valid    (win_valid),
    .win_ready    (win_ready),
    .win_info     (win_info),
    .win_diff     (win_diff)
  );

  dsm_eval #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_eval (
    .clk            (clk),
    .rst            (rst),
    .win_valid      (win_valid),
    .win_ready      (win_ready),
    .win_info       (win_info),
    .win_diff       (win_diff),
    .four_conn      (four_conn),
    .threshold      (threshold),
    .diag_threshold (diag_threshold),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata)
  );

endmodule

`default_nettype wire

// ===== sim/dsm_disturbance_mask_unit_tb.sv =====
// Self-checking testbench of the disturbance mask unit: raster frames in, mask beats checked.
`timescale 1ns / 1ps

module dsm_disturbance_mask_unit_tb;
  import dsm_pkg::*;

  localparam int MAX_COLS     = 4096;
  localparam int SETTLE_CYC   = 8;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int MAX_REPORTS  = 100;
  localparam int WIDE_COLS    = 160;
  localparam int TALL_ROWS    = 20;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             disturbed;
    logic             center_nd;
  } mask_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  wire                   s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  wire                   m_tvalid;
  logic                  m_tready = 1'b0;
  wire  [OUT_W-1:0]      m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register mirror, reset values
  logic               cfg_four   = 1'b1;
  logic [THR_W-1:0]   cfg_thr    = '0;
  logic [THR_W-1:0]   cfg_dthr   = '0;
  logic [IN_W-1:0]    cfg_nodata = '0;
  logic [IMG_W_W-1:0] cfg_width  = 13'd4096;
  logic [IMG_H_W-1:0] cfg_height = 16'd65535;

  logic [ROW_W-1:0]       row_cnt = '0;
  logic [COL_W-1:0]       col_cnt = '0;
  longint                 win [0:2][0:2];
  logic signed [IN_W-1:0] upper_line  [MAX_COLS];
  logic signed [IN_W-1:0] middle_line [MAX_COLS];

  mask_result_t pending_masks [$];
  mask_result_t head_mask;
  int           error_count = 0;
  int           quiet_cycles = 0;
  int           src_idle_pct = 0;
  int           sink_stall_pct = 0;
  int           frame_base = 0;

  dsm_disturbance_mask_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit step_over(longint a, longint b, longint lim);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    return d > lim;
  endfunction

  function automatic bit dir_over(longint first, longint ctr, longint second, longint nd,
                                  longint lim);
    if (first != nd && second != nd)
      return step_over(first, ctr, lim) || step_over(ctr, second, lim);
    if (first == nd)
      return step_over(ctr, second, lim);
    return step_over(first, ctr, lim);
  endfunction

  task automatic predict_mask(input logic [IN_W-1:0] raw);
    int unsigned  w;
    int unsigned  hh;
    int unsigned  r;
    int unsigned  c;
    longint       ctr;
    longint       nd;
    bit           dist_flag;
    mask_result_t res;
    w = cfg_width;
    if (w < 3) w = 3;
    if (w > MAX_COLS) w = MAX_COLS;
    hh = cfg_height;
    if (hh < 3) hh = 3;
    r = row_cnt;
    c = col_cnt % MAX_COLS;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper_line[c];
    win[1][2] = middle_line[c];
    win[2][2] = longint'($signed(raw));
    upper_line[c]  = middle_line[c];
    middle_line[c] = raw;
    if (r >= 2 && c >= 2) begin
      nd  = longint'($signed(cfg_nodata));
      ctr = win[1][1];
      res.row       = ROW_W'(r - 1);
      res.col       = COL_W'(c - 1);
      res.center_nd = (ctr == nd);
      dist_flag = 1'b0;
      if (!res.center_nd) begin
        dist_flag = dir_over(win[0][1], ctr, win[2][1], nd, cfg_thr)
                 && dir_over(win[1][0], ctr, win[1][2], nd, cfg_thr);
        if (!cfg_four)
          dist_flag = dist_flag
                   && dir_over(win[0][0], ctr, win[2][2], nd, cfg_dthr)
                   && dir_over(win[0][2], ctr, win[2][0], nd, cfg_dthr);
      end
      res.disturbed = dist_flag;
      pending_masks.push_back(res);
    end
    if (c + 1 >= w) begin
      c = 0;
      r = (r + 1 >= hh) ? 0 : r + 1;
    end else begin
      c = c + 1;
    end
    row_cnt = ROW_W'(r);
    col_cnt = COL_W'(c);
  endtask

  // mask beat checker and sink stalls
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_masks.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: mask beat with nothing expected, got %h", $time, m_tdata);
      end else begin
        head_mask = pending_masks.pop_front();
        if (m_tdata[15:0] !== head_mask.row || m_tdata[27:16] !== head_mask.col
            || m_tdata[28] !== head_mask.disturbed || m_tdata[29] !== head_mask.center_nd
            || m_tdata[31:30] !== 2'b00) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: mask mismatch, exp r%0d c%0d d%b n%b, got r%0d c%0d d%b n%b pad %b",
                     $time, head_mask.row, head_mask.col, head_mask.disturbed,
                     head_mask.center_nd, m_tdata[15:0], m_tdata[27:16], m_tdata[28],
                     m_tdata[29], m_tdata[31:30]);
        end
      end
    end
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  task automatic push_height(input logic [IN_W-1:0] h);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= h;
    do @(posedge clk); while (!s_tready);
    predict_mask(h);
  endtask

  task automatic hold_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_masks.size() != 0);
  endtask

  task automatic settle_unit();
    hold_for_results();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_FOUR_CONN:   cfg_four   = val[0];
      CFG_THRESHOLD:   cfg_thr    = val[THR_W-1:0];
      CFG_DIAG_THRESH: cfg_dthr   = val[THR_W-1:0];
      CFG_NODATA:      cfg_nodata = val[IN_W-1:0];
      CFG_IMG_WIDTH:   cfg_width  = val[IMG_W_W-1:0];
      CFG_IMG_HEIGHT:  cfg_height = val[IMG_H_W-1:0];
      default: ;
    endcase
  endtask

  task automatic setup_frame(input logic [31:0] four, input logic [31:0] thr,
                             input logic [31:0] dthr, input logic [31:0] nd,
                             input logic [31:0] w, input logic [31:0] h);
    write_reg(CFG_FOUR_CONN, four);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_DIAG_THRESH, dthr);
    write_reg(CFG_NODATA, nd);
    write_reg(CFG_IMG_WIDTH, w);
    write_reg(CFG_IMG_HEIGHT, h);
  endtask

  function automatic logic [31:0] draw_height();
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) return cfg_nodata;
    if (sel < 25)
      return frame_base + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(60000, 1000));
    if (sel < 30) return $urandom;
    if (sel < 33) return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return frame_base + int'($urandom_range(600)) - 300;
  endfunction

  function automatic logic [31:0] draw_limit();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom_range(600);
    if (sel < 70) return 32'd0;
    if (sel < 80) return 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  // 3x3 frame: max centre among min neighbors, every register but nodata with stray upper bits
  task automatic test_extreme_frame();
    set_idling(29, 29);
    setup_frame(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678,
                32'hFFFF_E003, 32'hFFFF_0002);
    repeat (4) push_height(32'h8000_0000);
    push_height(32'h7FFF_FFFF);
    repeat (4) push_height(32'h8000_0000);
    settle_unit();
  endtask

  // nodata on first, second, both neighbors and at the centre
  task automatic test_nodata_rules();
    localparam int ND = -1000;
    int seq [15] = '{0, ND, 0, 500, 0, ND, ND, 300, ND, 0, ND, 0, 0, 0, 0};
    set_idling(0, 0);
    setup_frame(32'd1, 32'd100, 32'd141, ND, 32'd0, 32'd5);
    foreach (seq[i]) push_height(seq[i]);
    settle_unit();
  endtask

  // wide rows pass through the line RAMs; last row runs with a width above the clamp
  task automatic test_full_width();
    set_idling(0, 0);
    frame_base = 0;
    setup_frame(32'd0, 32'd200, 32'd283, 32'h8000_0000, WIDE_COLS, 32'd4);
    repeat (3 * WIDE_COLS) push_height(draw_height());
    settle_unit();
    write_reg(CFG_IMG_WIDTH, 32'd8191);
    repeat (WIDE_COLS - 1) push_height(draw_height());
    settle_unit();
  endtask

  // narrowest width at the tallest frame setting, first rows only
  task automatic test_tall_frame();
    set_idling(0, 0);
    frame_base = 100;
    setup_frame(32'd1, 32'd150, 32'd212, 32'd0, 32'd3, 32'h0001_FFFF);
    repeat (3 * TALL_ROWS) push_height(draw_height());
    settle_unit();
  endtask

  task automatic test_random_frames();
    int          sent;
    int          frame;
    int          sel;
    int          w;
    int          h;
    int          n;
    logic [31:0] thr;
    logic [31:0] dthr;
    logic [31:0] nd;
    longint      scaled;
    sent  = 0;
    frame = 0;
    while (sent < RANDOM_ITEMS) begin
      settle_unit();
      case (frame % 4)
        0: set_idling(0, 0);
        1: set_idling(66, 0);
        2: set_idling(0, 66);
        default: set_idling(29, 29);
      endcase
      sel = $urandom_range(99);
      w = (sel < 80) ? $urandom_range(10, 3) : (sel < 93) ? $urandom_range(40, 11)
                                                          : $urandom_range(2, 0);
      sel = $urandom_range(99);
      h = (sel < 85) ? $urandom_range(8, 3) : (sel < 95) ? $urandom_range(20, 9)
                                                         : $urandom_range(2, 0);
      frame_base = int'($urandom_range(4000)) - 2000;
      thr = draw_limit();
      if ($urandom_range(99) < 60) begin
        scaled = longint'(thr[THR_W-1:0]) * 181 / 128;
        dthr = (scaled > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : scaled[31:0];
      end else begin
        dthr = draw_limit();
      end
      sel = $urandom_range(99);
      nd = (sel < 40) ? frame_base + int'($urandom_range(600)) - 300
         : (sel < 70) ? $urandom
         : (sel < 85) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      setup_frame($urandom_range(1), thr, dthr, nd, w, h);
      n = ((w < 3) ? 3 : w) * ((h < 3) ? 3 : h);
      // cut frames leave the counters mid-frame for the next setting
      if ($urandom_range(99) < 20) n = $urandom_range(n, 1);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(199) == 0 || (frame == 1 && k == n / 2))
          hold_for_results();
        push_height(draw_height());
      end
      sent += n;
      frame++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extreme_frame();
    test_nodata_rules();
    test_full_width();
    test_tall_frame();
    test_random_frames();
    settle_unit();
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
design/dsm_pkg.sv
design/dsm_ram.sv
design/dsm_window.sv
design/dsm_eval.sv
design/dsm_disturbance_mask_unit.sv
sim/dsm_disturbance_mask_unit_tb.sv
